@@ rtl/pbpm_pkg.sv @@
// Shared types, constants and codes for the packet buffer pool manager.
package pbpm_pkg;

   localparam int TX_POOL_SIZE_DEF  = 16;
   localparam int RX_POOL_SIZE_DEF  = 16;
   localparam int HEADROOM_DEF      = 64;
   localparam int FRAME_MAX_DEF     = 1600;
   localparam int BUFFER_STRIDE_DEF = 2048;

   localparam int IDX_W = 4;
   localparam int LEN_W = 11;
   localparam int CNT_W = 8;
   localparam int TOP_W = 5;
   localparam int ADDR_W = 32;

   typedef enum logic [2:0] {
      MODE_ALLOC_TX = 3'd0,
      MODE_ALLOC_RX = 3'd1,
      MODE_REF      = 3'd2,
      MODE_RELEASE  = 3'd3,
      MODE_PUSH     = 3'd4,
      MODE_PULL     = 3'd5,
      MODE_PUT      = 3'd6,
      MODE_UNUSED   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_NOBUF  = 3'd2,
      ST_BOUNDS = 3'd3,
      ST_SAT    = 3'd4
   } status_type;

   localparam logic CSR_TX_BASE = 1'b0;
   localparam logic CSR_RX_BASE = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch request and read tables
      logic execute;   // compute, update state, load result
   } cmd_type;

   typedef struct packed {
      logic done;      // result register loaded
   } stat_type;

endpackage

@@ rtl/pbpm_ctrl.sv @@
// Controller state machine: capture, execute, then hold result until taken.
module pbpm_ctrl
   import pbpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == S_EXEC);

   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute) else $error("execute did not follow capture");
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_valid && stat.done)) else $error("result not presented");
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

endmodule

@@ rtl/pbpm_dp.sv @@
// Datapath: free stacks, per-buffer tables, bounds checks and result register.
module pbpm_dp
   import pbpm_pkg::*;
#(
   parameter int TX_POOL_SIZE  = TX_POOL_SIZE_DEF,
   parameter int RX_POOL_SIZE  = RX_POOL_SIZE_DEF,
   parameter int HEADROOM      = HEADROOM_DEF,
   parameter int FRAME_MAX     = FRAME_MAX_DEF,
   parameter int BUFFER_STRIDE = BUFFER_STRIDE_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_valid,
   input  logic [0:0]         csr_index,
   input  logic [ADDR_W-1:0]  csr_data,
   input  logic [2:0]         req_mode,
   input  logic               req_buffer_pool,
   input  logic [IDX_W-1:0]   req_buffer_index,
   input  logic [LEN_W-1:0]   req_request_length,
   output logic [2:0]         rsp_status,
   output logic               rsp_result_pool,
   output logic [IDX_W-1:0]   rsp_result_index,
   output logic [LEN_W-1:0]   rsp_region_offset,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic [ADDR_W-1:0]  rsp_region_address,
   output logic [CNT_W-1:0]   rsp_reference_count,
   output logic               rsp_released,
   output logic [TOP_W-1:0]   rsp_tx_free_count,
   output logic [TOP_W-1:0]   rsp_rx_free_count
);

   localparam int SLOTS  = 2 * (1 << IDX_W);
   localparam int SLOT_W = IDX_W + 1;
   localparam int WIDE_W = 16;
   localparam logic [WIDE_W-1:0] LIMIT = WIDE_W'(HEADROOM + FRAME_MAX);

   logic [ADDR_W-1:0] tx_base_ff, rx_base_ff;
   logic [IDX_W-1:0]  tx_stack_ff [1 << IDX_W];
   logic [IDX_W-1:0]  rx_stack_ff [1 << IDX_W];
   logic [TOP_W-1:0]  tx_top_ff, rx_top_ff;
   logic [CNT_W-1:0]  cnt_ff [SLOTS];
   logic [LEN_W-1:0]  off_ff [SLOTS];
   logic [LEN_W-1:0]  flen_ff [SLOTS];

   // Captured request and operands read in the capture cycle.
   mode_type          mode_ff;
   logic              pool_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [CNT_W-1:0]  rcnt_ff;
   logic [LEN_W-1:0]  roff_ff, rflen_ff;
   logic [IDX_W-1:0]  pop_ff;
   logic              empty_ff;

   logic [SLOT_W-1:0] cap_slot;
   logic [TOP_W-1:0]  cap_top;
   logic              cap_alloc_rx;

   assign cap_alloc_rx = (req_mode == MODE_ALLOC_RX);
   assign cap_top  = cap_alloc_rx ? rx_top_ff : tx_top_ff;
   assign cap_slot = {req_buffer_pool, req_buffer_index};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         pool_ff  <= req_buffer_pool;
         idx_ff   <= req_buffer_index;
         len_ff   <= req_request_length;
         rcnt_ff  <= cnt_ff[cap_slot];
         roff_ff  <= off_ff[cap_slot];
         rflen_ff <= flen_ff[cap_slot];
         empty_ff <= (cap_top == '0);
         pop_ff   <= cap_alloc_rx ? rx_stack_ff[IDX_W'(cap_top - 1'b1)]
                                  : tx_stack_ff[IDX_W'(cap_top - 1'b1)];
      end
   end

   // Execute-cycle evaluation.
   logic [2:0]        st;
   logic              w_pool;
   logic [IDX_W-1:0]  w_idx;
   logic [LEN_W-1:0]  w_off, w_flen;
   logic [CNT_W-1:0]  w_cnt;
   logic              w_rel, w_region, upd;
   logic [LEN_W-1:0]  n_off, n_flen;
   logic [CNT_W-1:0]  n_cnt;
   logic              do_pop, do_push;
   logic [WIDE_W-1:0] tail_w;
   logic              bad_idx;
   logic [TOP_W-1:0]  ptop;
   int unsigned       psize;

   always_comb begin
      st = ST_OK; w_pool = pool_ff; w_idx = idx_ff; w_off = '0; w_flen = '0;
      w_cnt = '0; w_rel = 1'b0; w_region = 1'b0; upd = 1'b0;
      n_off = roff_ff; n_flen = rflen_ff; n_cnt = rcnt_ff;
      do_pop = 1'b0; do_push = 1'b0;
      tail_w = WIDE_W'(roff_ff) + WIDE_W'(rflen_ff);
      psize = pool_ff ? RX_POOL_SIZE : TX_POOL_SIZE;
      ptop = pool_ff ? rx_top_ff : tx_top_ff;
      bad_idx = (32'(idx_ff) >= psize);
      if (mode_ff == MODE_ALLOC_TX || mode_ff == MODE_ALLOC_RX) begin
         w_pool = (mode_ff == MODE_ALLOC_RX);
         if (empty_ff) begin
            st = ST_EMPTY; w_idx = '0;
         end else begin
            w_idx = pop_ff; do_pop = 1'b1; upd = 1'b1;
            n_cnt = CNT_W'(1); n_off = LEN_W'(HEADROOM); n_flen = '0;
            w_cnt = n_cnt; w_region = 1'b1;
         end
      end else if (mode_ff == MODE_UNUSED || bad_idx) begin
         st = ST_NOBUF;
      end else begin
         w_cnt = rcnt_ff;
         if (rcnt_ff == '0) begin
            st = ST_NOBUF;
         end else begin
            case (mode_ff)
               MODE_REF: begin
                  if (rcnt_ff == '1) st = ST_SAT;
                  else begin
                     n_cnt = rcnt_ff + 1'b1; upd = 1'b1; w_cnt = n_cnt; w_region = 1'b1;
                  end
               end
               MODE_RELEASE: begin
                  n_cnt = rcnt_ff - 1'b1; upd = 1'b1; w_cnt = n_cnt; w_region = 1'b1;
                  if (n_cnt == '0) begin
                     w_rel = 1'b1;
                     do_push = (32'(ptop) < psize);
                  end
               end
               MODE_PUSH: begin
                  if (len_ff > roff_ff) st = ST_BOUNDS;
                  else begin
                     n_off = roff_ff - len_ff; n_flen = rflen_ff + len_ff;
                     upd = 1'b1; w_region = 1'b1;
                  end
               end
               MODE_PULL: begin
                  if (len_ff > rflen_ff) st = ST_BOUNDS;
                  else begin
                     n_off = roff_ff + len_ff; n_flen = rflen_ff - len_ff;
                     upd = 1'b1; w_region = 1'b1;
                  end
               end
               default: begin
                  if (tail_w + WIDE_W'(len_ff) > LIMIT) st = ST_BOUNDS;
                  else begin
                     n_flen = rflen_ff + len_ff; upd = 1'b1;
                     w_off = LEN_W'(tail_w); w_flen = n_flen;
                  end
               end
            endcase
         end
      end
      if (w_region) begin
         w_off = n_off; w_flen = n_flen;
      end
   end

   logic [SLOT_W-1:0] w_slot;
   logic [ADDR_W-1:0] w_addr;
   logic              any_region;
   assign w_slot = {w_pool, w_idx};
   assign any_region = (st == ST_OK) && (mode_ff != MODE_UNUSED);
   assign w_addr = any_region ? ((w_pool ? rx_base_ff : tx_base_ff)
                   + ADDR_W'(w_idx) * ADDR_W'(BUFFER_STRIDE) + ADDR_W'(w_off)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_top_ff <= TOP_W'(TX_POOL_SIZE);
         rx_top_ff <= TOP_W'(RX_POOL_SIZE);
         tx_base_ff <= '0;
         rx_base_ff <= '0;
         for (int i = 0; i < (1 << IDX_W); i++) begin
            tx_stack_ff[i] <= IDX_W'(i);
            rx_stack_ff[i] <= IDX_W'(i);
         end
         for (int i = 0; i < SLOTS; i++) cnt_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_TX_BASE) tx_base_ff <= csr_data;
            else rx_base_ff <= csr_data;
         end
         if (cmd.execute) begin
            if (upd) cnt_ff[w_slot] <= n_cnt;
            if (do_pop) begin
               if (w_pool) rx_top_ff <= rx_top_ff - 1'b1;
               else tx_top_ff <= tx_top_ff - 1'b1;
            end
            if (do_push) begin
               if (w_pool) begin
                  rx_stack_ff[IDX_W'(rx_top_ff)] <= w_idx;
                  rx_top_ff <= rx_top_ff + 1'b1;
               end else begin
                  tx_stack_ff[IDX_W'(tx_top_ff)] <= w_idx;
                  tx_top_ff <= tx_top_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && upd) begin
         off_ff[w_slot]  <= n_off;
         flen_ff[w_slot] <= n_flen;
      end
   end

   // Result register; free counts sampled after the update.
   logic [TOP_W-1:0] ntx, nrx;
   always_comb begin
      ntx = tx_top_ff; nrx = rx_top_ff;
      if (do_pop) begin
         if (w_pool) nrx = rx_top_ff - 1'b1; else ntx = tx_top_ff - 1'b1;
      end
      if (do_push) begin
         if (w_pool) nrx = rx_top_ff + 1'b1; else ntx = tx_top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status          <= st;
         rsp_result_pool     <= w_pool;
         rsp_result_index    <= w_idx;
         rsp_region_offset   <= any_region ? w_off : '0;
         rsp_frame_length    <= any_region ? w_flen : '0;
         rsp_region_address  <= w_addr;
         rsp_reference_count <= w_cnt;
         rsp_released        <= (st == ST_OK) && w_rel;
         rsp_tx_free_count   <= ntx;
         rsp_rx_free_count   <= nrx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stat.done <= 1'b0;
      else stat.done <= cmd.execute;
   end

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      32'(tx_top_ff) <= TX_POOL_SIZE) else $error("tx free top out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && do_pop |-> !empty_ff) else $error("pop from empty pool");
   a_no_pop_push: assert property (@(posedge clock) disable iff (reset)
      !(do_pop && do_push)) else $error("pop and push together");

endmodule

@@ rtl/packet_buffer_pool_manager.sv @@
// Top level of the packet buffer pool manager: controller plus datapath.
// An accepted item passes capture/read, then execute, which loads the result register.
// A new item is not accepted until the result is taken: the
//   result register is held until rsp_ready, and ready drops meanwhile.
// The read-modify-write of the per-buffer tables and free stacks is why items do not overlap.
// Reset: synchronous active high; free stacks reload with index i at entry i,
//   free counts to pool size, reference counts and pool bases to zero, at once.
module packet_buffer_pool_manager
   import pbpm_pkg::*;
#(
   parameter int TX_POOL_SIZE  = TX_POOL_SIZE_DEF,
   parameter int RX_POOL_SIZE  = RX_POOL_SIZE_DEF,
   parameter int HEADROOM      = HEADROOM_DEF,
   parameter int FRAME_MAX     = FRAME_MAX_DEF,
   parameter int BUFFER_STRIDE = BUFFER_STRIDE_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [ADDR_W-1:0] csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_mode,
   input  logic              req_buffer_pool,
   input  logic [IDX_W-1:0]  req_buffer_index,
   input  logic [LEN_W-1:0]  req_request_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic              rsp_result_pool,
   output logic [IDX_W-1:0]  rsp_result_index,
   output logic [LEN_W-1:0]  rsp_region_offset,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic [ADDR_W-1:0] rsp_region_address,
   output logic [CNT_W-1:0]  rsp_reference_count,
   output logic              rsp_released,
   output logic [TOP_W-1:0]  rsp_tx_free_count,
   output logic [TOP_W-1:0]  rsp_rx_free_count
);

   cmd_type  cmd;
   stat_type stat;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   pbpm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat
   );

   pbpm_dp #(
      .TX_POOL_SIZE(TX_POOL_SIZE), .RX_POOL_SIZE(RX_POOL_SIZE),
      .HEADROOM(HEADROOM), .FRAME_MAX(FRAME_MAX), .BUFFER_STRIDE(BUFFER_STRIDE)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .csr_valid, .csr_index, .csr_data,
      .req_mode, .req_buffer_pool, .req_buffer_index, .req_request_length,
      .rsp_status, .rsp_result_pool, .rsp_result_index, .rsp_region_offset,
      .rsp_frame_length, .rsp_region_address, .rsp_reference_count,
      .rsp_released, .rsp_tx_free_count, .rsp_rx_free_count
   );

endmodule
